// File: src/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes and status codes for the PID controller
// with magnitude clamp.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // default width of the measured and target samples
  localparam int DATA_W_DEF = 16;

  // fixed field widths
  localparam int GAIN_W   = 16;
  localparam int RANGE_W  = 15;
  localparam int DRIVE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int INTEG_W  = 32;
  localparam int Q_FRAC   = 8;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_OUT_MIN    = 3'd3,
    REG_OUT_MAX    = 3'd4
  } cfg_idx_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_GAIN  = 2'd1,
    STATUS_NO_RANGE = 2'd2
  } status_t;

endpackage

// File: src/pid_controller_magnitude_clamp_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_magnitude_clamp_unit: PID step with signed magnitude clamp
// Pipeline: the input transfer is registered in stage A (input), then B (product), then C (result).
// Throughput: one item per cycle while out_stall is low; the three-stage valid/stall pipeline sets it.
// Reset: clears gains, range, integral sum, previous sample and all valids.
// ----------------------------------------------------------------------------
module pid_controller_magnitude_clamp_unit #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_W_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidc_pkg::GAIN_W-1:0]           cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [DATA_WIDTH-1:0]          measured,
  input  logic signed [DATA_WIDTH-1:0]          target,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pidc_pkg::DRIVE_W-1:0]   drive,
  output logic [pidc_pkg::STATUS_W-1:0]         status
);

  import pidc_pkg::*;

  // derived widths
  localparam int DIFF_W = DATA_WIDTH + 1;              // error and derivative
  localparam int PD_W   = GAIN_W + DIFF_W;             // P and D products
  localparam int PI_W   = GAIN_W + INTEG_W;            // I product
  localparam int QD_W   = PD_W - Q_FRAC;               // truncated P and D
  localparam int QI_W   = PI_W - Q_FRAC;               // truncated I
  localparam int QMAX_W = (QD_W > QI_W) ? QD_W : QI_W;
  localparam int SUM_W  = QMAX_W + 2;
  localparam int NI_W   = INTEG_W + 2;
  localparam int Q_ROUND = (1 << Q_FRAC) - 1;

  // configuration registers
  logic signed [GAIN_W-1:0]  prop_gain;
  logic signed [GAIN_W-1:0]  integ_gain;
  logic signed [GAIN_W-1:0]  deriv_gain;
  logic [RANGE_W-1:0]        out_min;
  logic [RANGE_W-1:0]        out_max;

  // loop state
  logic signed [INTEG_W-1:0]    integ_sum;
  logic signed [DATA_WIDTH-1:0] prev_meas;
  logic signed [INTEG_W-1:0]    integ_sum_next;

  // stage A: input register
  logic                         a_valid;
  logic signed [DATA_WIDTH-1:0] a_meas;
  logic signed [DATA_WIDTH-1:0] a_tgt;

  // stage B: product register
  logic                  b_valid;
  logic signed [QD_W-1:0] b_prop;
  logic signed [QI_W-1:0] b_integ;
  logic signed [QD_W-1:0] b_deriv;
  status_t               b_status;

  // handshake chain
  logic c_ready;
  logic b_ready;
  logic a_ready;
  logic a_adv;

  // stage A datapath
  logic signed [DIFF_W-1:0] err;
  logic signed [DIFF_W-1:0] der;
  logic signed [PD_W-1:0]   prop_prod;
  logic signed [PI_W-1:0]   integ_prod;
  logic signed [PD_W-1:0]   deriv_prod;
  logic [PD_W-1:0]          prop_adj;
  logic [PI_W-1:0]          integ_adj;
  logic [PD_W-1:0]          deriv_adj;
  logic                     gains_zero;
  logic                     range_zero;
  status_t                  a_status;
  logic signed [NI_W-1:0]   integ_wide;

  // stage B datapath
  logic signed [SUM_W-1:0] sum;
  logic                    sum_neg;
  logic [SUM_W-1:0]        mag;
  logic [RANGE_W-1:0]      clamp_mag;
  logic [DRIVE_W-1:0]      drive_next;

  // --------------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      out_min    <= '0;
      out_max    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        REG_OUT_MIN:    out_min    <= cfg_data[RANGE_W-1:0];
        REG_OUT_MAX:    out_max    <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: a stage takes a new item when empty or draining
  // --------------------------------------------------------------------------
  assign c_ready  = !out_valid || !out_stall;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign a_adv    = a_valid && b_ready;
  assign in_stall = !a_ready;

  // --------------------------------------------------------------------------
  // Stage A: capture the sample on transfer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_meas <= measured;
      a_tgt  <= target;
    end
  end

  // --------------------------------------------------------------------------
  // Error, derivative and the three gain products
  // --------------------------------------------------------------------------
  assign err = DIFF_W'(a_tgt) - DIFF_W'(a_meas);
  assign der = DIFF_W'(a_meas) - DIFF_W'(prev_meas);

  assign prop_prod  = prop_gain * err;
  assign integ_prod = integ_gain * integ_sum;
  assign deriv_prod = deriv_gain * der;

  // bias negative products so the shift truncates toward zero
  assign prop_adj  = prop_prod +
                     (prop_prod[PD_W-1] ? PD_W'(Q_ROUND) : PD_W'(0));
  assign integ_adj = integ_prod +
                     (integ_prod[PI_W-1] ? PI_W'(Q_ROUND) : PI_W'(0));
  assign deriv_adj = deriv_prod +
                     (deriv_prod[PD_W-1] ? PD_W'(Q_ROUND) : PD_W'(0));

  // error checks; missing gains take precedence over a missing range
  assign gains_zero = (prop_gain == '0) && (integ_gain == '0) && (deriv_gain == '0);
  assign range_zero = (out_min == '0) && (out_max == '0);

  always_comb begin
    priority if (gains_zero) begin
      a_status = STATUS_NO_GAIN;
    end else if (range_zero) begin
      a_status = STATUS_NO_RANGE;
    end else begin
      a_status = STATUS_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Integral update with 32-bit saturation
  // --------------------------------------------------------------------------
  assign integ_wide = NI_W'(integ_sum) + NI_W'(err);

  always_comb begin
    priority if (integ_wide[NI_W-1] && !(&integ_wide[NI_W-2:INTEG_W-1])) begin
      integ_sum_next = {1'b1, {(INTEG_W-1){1'b0}}};
    end else if (!integ_wide[NI_W-1] && (|integ_wide[NI_W-2:INTEG_W-1])) begin
      integ_sum_next = {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sum_next = integ_wide[INTEG_W-1:0];
    end
  end

  // advance loop state as an ok item leaves stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_sum <= '0;
      prev_meas <= '0;
    end else if (a_adv && (a_status == STATUS_OK)) begin
      integ_sum <= integ_sum_next;
      prev_meas <= a_meas;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: hold truncated products and status
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_prop   <= $signed(prop_adj[PD_W-1:Q_FRAC]);
      b_integ  <= $signed(integ_adj[PI_W-1:Q_FRAC]);
      b_deriv  <= $signed(deriv_adj[PD_W-1:Q_FRAC]);
      b_status <= a_status;
    end
  end

  // --------------------------------------------------------------------------
  // Sum the terms and clamp the magnitude, keeping the sign
  // --------------------------------------------------------------------------
  assign sum     = SUM_W'(b_prop) + SUM_W'(b_integ) + SUM_W'(b_deriv);
  assign sum_neg = sum[SUM_W-1];
  assign mag     = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);

  always_comb begin
    priority if (mag < SUM_W'(out_min)) begin
      clamp_mag = out_min;
    end else if (mag > SUM_W'(out_max)) begin
      clamp_mag = out_max;
    end else begin
      clamp_mag = mag[RANGE_W-1:0];
    end
  end

  always_comb begin
    if (b_status != STATUS_OK) begin
      drive_next = '1;
    end else if (sum_neg) begin
      drive_next = DRIVE_W'(-{1'b0, clamp_mag});
    end else begin
      drive_next = DRIVE_W'({1'b0, clamp_mag});
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_ready) begin
      drive  <= drive_next;
      status <= b_status;
    end
  end

`ifndef SYNTHESIS
  // an error result always drives all ones
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_OK)) |-> (drive == '1))
    else $error("error status without drive of -1");

  // an error item leaves the loop state untouched
  assert property (@(posedge clk) disable iff (rst)
    (a_adv && (a_status != STATUS_OK)) |=> ($stable(integ_sum) && $stable(prev_meas)))
    else $error("loop state changed on an error item");

  // a blocked product stage keeps its item
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_ready) |=> (b_valid && $stable(b_status) && $stable(b_integ)))
    else $error("product stage lost an item");

  // an empty input stage never stalls the sender
  assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> !in_stall)
    else $error("stall raised with an empty input stage");
`endif

endmodule
